FILE: design/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
// Holds the transaction structs, codes, controller states and command/status bundles.
// No dependencies.
`default_nettype none

package ptt_pkg;

	// Table depth default and arithmetic widths
	localparam int TIMER_SLOTS_DEF = 16;
	localparam int TIME_W          = 48;
	localparam int LIMIT_W         = 36;
	localparam int USEC_PER_SEC    = 1000000;

	// Request modes
	localparam logic [1:0] MODE_CHECK  = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	// Event kinds
	localparam logic [2:0] KIND_FIRE       = 3'd0;
	localparam logic [2:0] KIND_STOPPED    = 3'd1;
	localparam logic [2:0] KIND_ADDED      = 3'd2;
	localparam logic [2:0] KIND_BAD_PERIOD = 3'd3;
	localparam logic [2:0] KIND_FULL       = 3'd4;
	localparam logic [2:0] KIND_NOT_FOUND  = 3'd5;
	localparam logic [2:0] KIND_CHECK_DONE = 3'd6;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] now_time;
		logic [7:0]        owner_id;
		logic [15:0]       timer_num;
		logic [15:0]       period_seconds;
		logic [31:0]       context_tag;
		logic              fire_now;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  event_owner;
		logic [15:0] event_timer;
		logic [31:0] event_context;
		logic [15:0] alarm_period;
		logic        last;
	} evt_t;

	// One stored timer
	typedef struct packed {
		logic [7:0]        owner;
		logic [15:0]       timer;
		logic [15:0]       period;
		logic [TIME_W-1:0] stamp;
		logic [31:0]       context_tag;
	} slot_t;

	// Where the fields of an emitted event come from
	typedef enum logic [1:0] {
		SRC_REQ,
		SRC_REQ_NOCTX,
		SRC_ENTRY,
		SRC_NONE
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REJECT,
		ST_ADD_FIRE,
		ST_ADD_DONE,
		ST_CHK_RD,
		ST_CHK_CALC,
		ST_CHK_CMP,
		ST_CHK_DONE,
		ST_DEL_RD,
		ST_DEL_CMP,
		ST_DEL_STOP,
		ST_DEL_MISS,
		ST_CMP_RD,
		ST_CMP_WR
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       accept;
		logic       idx_zero;
		logic       idx_top;
		logic       idx_inc;
		logic       idx_dec;
		logic       rd_next;
		logic       add_write;
		logic       stamp_write;
		logic       shift_write;
		logic       count_dec;
		logic       calc;
		logic       capture;
		logic       emit;
		logic [2:0] emit_kind;
		src_t       emit_src;
		logic       emit_last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       fire_now;
		logic       period_zero;
		logic       table_full;
		logic       count_zero;
		logic       idx_zero;
		logic       idx_last;
		logic       compact_end;
		logic       fire_due;
		logic       match;
		logic       out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: design/periodic_timer_table.sv
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_stall
// evt      out        evt_t    evt_valid / evt_stall
//
// One request at a time, through a sequencer on a one-write, one-read slot RAM.
// Check: accept, decode, then read, compute and compare per stored timer, then done,
// waiting while events stall. Add: accept, decode, a fire if immediate, then added.
// Delete: read, compare per slot from the newest; then read, write per slot shifted.
// Reset clears the fill count and sets the minimum period to 1; no RAM clearing pass.
// Events wait in one output register; the sequencer holds while it is full and stalled.
`default_nettype none

module periodic_timer_table
	import ptt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      evt_valid,
	input  wire logic evt_stall,
	output evt_t      evt
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Table and event datapath
	ptt_dp #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

endmodule

`default_nettype wire

FILE: design/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/ptt_ctrl.sv
// Sequencer for the periodic timer table: walks check, add and delete transactions.
// Depends on ptt_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module ptt_ctrl
	import ptt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (stat.mode)
					MODE_CHECK:  state_d = stat.count_zero ? ST_CHK_DONE : ST_CHK_RD;
					MODE_ADD: begin
						if (stat.period_zero || stat.table_full) state_d = ST_REJECT;
						else if (stat.fire_now) state_d = ST_ADD_FIRE;
						else state_d = ST_ADD_DONE;
					end
					MODE_DELETE: state_d = stat.count_zero ? ST_DEL_MISS : ST_DEL_RD;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_REJECT, ST_ADD_DONE, ST_CHK_DONE, ST_DEL_MISS: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_ADD_FIRE: begin
				if (stat.out_free) state_d = ST_ADD_DONE;
			end
			ST_CHK_RD:   state_d = ST_CHK_CALC;
			ST_CHK_CALC: state_d = ST_CHK_CMP;
			ST_CHK_CMP: begin
				if (!stat.fire_due || stat.out_free) begin
					state_d = stat.idx_last ? ST_CHK_DONE : ST_CHK_RD;
				end
			end
			ST_DEL_RD: state_d = ST_DEL_CMP;
			ST_DEL_CMP: begin
				if (stat.match) state_d = ST_DEL_STOP;
				else if (stat.idx_zero) state_d = ST_DEL_MISS;
				else state_d = ST_DEL_RD;
			end
			ST_DEL_STOP: begin
				if (stat.out_free) state_d = stat.idx_last ? ST_IDLE : ST_CMP_RD;
			end
			ST_CMP_RD: state_d = ST_CMP_WR;
			ST_CMP_WR: state_d = stat.compact_end ? ST_IDLE : ST_CMP_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		cmd.emit_src = SRC_NONE;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.accept = req_valid;
			end
			ST_DECODE: begin
				case (stat.mode)
					MODE_CHECK: cmd.idx_zero = 1'b1;
					MODE_ADD: begin
						cmd.add_write = !(stat.period_zero || stat.table_full);
					end
					MODE_DELETE: cmd.idx_top = !stat.count_zero;
					default: ;
				endcase
			end
			ST_REJECT: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = stat.period_zero ? KIND_BAD_PERIOD : KIND_FULL;
				cmd.emit_src  = SRC_REQ;
				cmd.emit_last = 1'b1;
			end
			ST_ADD_FIRE: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_FIRE;
				cmd.emit_src  = SRC_REQ;
			end
			ST_ADD_DONE: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_ADDED;
				cmd.emit_src  = SRC_REQ;
				cmd.emit_last = 1'b1;
			end
			ST_CHK_CALC: begin
				cmd.calc    = 1'b1;
				cmd.capture = 1'b1;
			end
			ST_CHK_CMP: begin
				cmd.emit        = stat.fire_due && stat.out_free;
				cmd.stamp_write = stat.fire_due && stat.out_free;
				cmd.idx_inc     = !stat.fire_due || stat.out_free;
				cmd.emit_kind   = KIND_FIRE;
				cmd.emit_src    = SRC_ENTRY;
			end
			ST_CHK_DONE: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_CHECK_DONE;
				cmd.emit_src  = SRC_NONE;
				cmd.emit_last = 1'b1;
			end
			ST_DEL_CMP: begin
				cmd.capture = 1'b1;
				cmd.idx_dec = !stat.match && !stat.idx_zero;
			end
			ST_DEL_STOP: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_STOPPED;
				cmd.emit_src  = SRC_ENTRY;
				cmd.emit_last = 1'b1;
				cmd.count_dec = stat.out_free && stat.idx_last;
			end
			ST_DEL_MISS: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_NOT_FOUND;
				cmd.emit_src  = SRC_REQ_NOCTX;
				cmd.emit_last = 1'b1;
			end
			ST_CMP_RD: begin
				cmd.rd_next = 1'b1;
			end
			ST_CMP_WR: begin
				cmd.shift_write = 1'b1;
				cmd.idx_inc     = 1'b1;
				cmd.count_dec   = stat.compact_end;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/ptt_dp.sv
// Datapath of the periodic timer table: slot RAM, fill count, index, elapsed-time
// compare, running minimum period and the event output register.
// Depends on ptt_pkg and ptt_ram; driven by ptt_ctrl.
`default_nettype none

module ptt_dp
	import ptt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req,
	input  wire dp_cmd_t cmd,
	output dp_stat_t     stat,
	output logic         evt_valid,
	input  wire logic    evt_stall,
	output evt_t         evt
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	req_t               req_q;
	slot_t              entry_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [15:0]        min_period_q;
	logic               min_known_q;
	logic               out_valid_q;
	evt_t               out_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [IW-1:0]      ram_raddr;
	slot_t              ram_wdata;
	slot_t              ram_rdata;
	evt_t               evt_d;
	logic               out_free;

	// Slot storage
	ptt_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(TIMER_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Select write source: append, restamp in place, or shift down one slot
	always_comb begin
		ram_we    = cmd.add_write || cmd.stamp_write || cmd.shift_write;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		if (cmd.add_write) begin
			ram_waddr             = count_q[IW-1:0];
			ram_wdata.owner       = req_q.owner_id;
			ram_wdata.timer       = req_q.timer_num;
			ram_wdata.period      = req_q.period_seconds;
			ram_wdata.stamp       = req_q.now_time;
			ram_wdata.context_tag = req_q.context_tag;
		end else if (cmd.stamp_write) begin
			ram_wdata       = entry_q;
			ram_wdata.stamp = req_q.now_time;
		end
	end

	assign ram_raddr = cmd.rd_next ? (idx_q + IW'(1)) : idx_q;

	// Hold the transaction being worked on and the slot under test
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.capture) begin
			entry_q <= ram_rdata;
		end
		if (cmd.calc) begin
			elapsed_q <= req_q.now_time - ram_rdata.stamp;
			limit_q   <= LIMIT_W'(ram_rdata.period) * LIMIT_W'(USEC_PER_SEC);
		end
	end

	// Fill count, walk index and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			min_period_q <= 16'd1;
			min_known_q  <= 1'b0;
		end else begin
			if (cmd.add_write) begin
				count_q     <= count_q + CW'(1);
				min_known_q <= 1'b1;
				if (!min_known_q || req_q.period_seconds < min_period_q) begin
					min_period_q <= req_q.period_seconds;
				end
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_top) begin
				idx_q <= IW'(count_q - CW'(1));
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - IW'(1);
			end
		end
	end

	// Build the next event
	always_comb begin
		evt_d.kind         = cmd.emit_kind;
		evt_d.alarm_period = min_period_q;
		evt_d.last         = cmd.emit_last;
		case (cmd.emit_src)
			SRC_REQ: begin
				evt_d.event_owner   = req_q.owner_id;
				evt_d.event_timer   = req_q.timer_num;
				evt_d.event_context = req_q.context_tag;
			end
			SRC_REQ_NOCTX: begin
				evt_d.event_owner   = req_q.owner_id;
				evt_d.event_timer   = req_q.timer_num;
				evt_d.event_context = '0;
			end
			SRC_ENTRY: begin
				evt_d.event_owner   = entry_q.owner;
				evt_d.event_timer   = entry_q.timer;
				evt_d.event_context = entry_q.context_tag;
			end
			default: begin
				evt_d.event_owner   = '0;
				evt_d.event_timer   = '0;
				evt_d.event_context = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || !evt_stall;

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!evt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= evt_d;
		end
	end

	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	// Status back to the sequencer
	always_comb begin
		stat.mode        = req_q.mode;
		stat.fire_now    = req_q.fire_now;
		stat.period_zero = (req_q.period_seconds == 16'd0);
		stat.table_full  = ({1'b0, count_q} >= (CW + 1)'(TIMER_SLOTS));
		stat.count_zero  = (count_q == '0);
		stat.idx_zero    = (idx_q == '0);
		stat.idx_last    = ((CW + 1)'(idx_q) + (CW + 1)'(1) == {1'b0, count_q});
		stat.compact_end = ((CW + 1)'(idx_q) + (CW + 1)'(2) == {1'b0, count_q});
		stat.fire_due    = (elapsed_q >= TIME_W'(limit_q));
		stat.match       = (ram_rdata.owner == req_q.owner_id) &&
		                   (ram_rdata.timer == req_q.timer_num);
		stat.out_free    = out_free;
	end

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW + 1)'(TIMER_SLOTS))
		else $error("fill count beyond table depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !evt_stall))
		else $error("event loaded over a held event");

	a_min_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!min_known_q |-> (min_period_q == 16'd1))
		else $error("minimum period moved before first add");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_write |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the table");

endmodule

`default_nettype wire
